@@ sv/pfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared widths, register codes, reset values and constants of the Phong
// fragment shader pipeline.
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int COL_W     = 8;
    localparam int POS_W     = 16;
    localparam int NRM_W     = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // light/eye minus position, and the reflected ray before normalizing
    localparam int DIR_W  = POS_W + 1;
    localparam int REFL_W = 22;

    // signed 1.14 unit vectors
    localparam int UNIT_W    = 16;
    localparam int QUOT_BITS = 15;

    localparam int DOT_W  = 32;
    localparam int DIFF_W = 17;
    localparam int SPEC_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RGB = 3'd6;

    localparam logic [POS_W-1:0] RST_LIGHT_X   = 16'd8192;
    localparam logic [POS_W-1:0] RST_LIGHT_Y   = 16'd8192;
    localparam logic [POS_W-1:0] RST_LIGHT_Z   = 16'd0;
    localparam logic [POS_W-1:0] RST_EYE_X     = 16'd0;
    localparam logic [POS_W-1:0] RST_EYE_Y     = 16'd0;
    localparam logic [POS_W-1:0] RST_EYE_Z     = 16'd6963;
    localparam logic [CFG_W-1:0] RST_LIGHT_RGB = 24'hFFFFFF;

    localparam logic [DIFF_W-1:0] AMBIENT_Q14 = 17'd4915;
    localparam logic [13:0]       SPEC_WT_Q14 = 14'd9830;
    localparam logic [SPEC_W-1:0] SPEC_MAX    = 15'd16384;
    // half of 255 * 2^28, for round to nearest
    localparam logic [48:0]       SHADE_RND   = 49'd34225520640;
    // 255 * 256: every quotient by 255 at or above this saturates
    localparam logic [20:0]       SAT_LIM     = 21'd65280;

    typedef logic signed [UNIT_W-1:0] t_unit;

    typedef struct packed {
        logic [COL_W-1:0] b;
        logic [COL_W-1:0] g;
        logic [COL_W-1:0] r;
    } t_rgb;

    // result bits of the square root for a w-bit signed vector
    function automatic int sqrt_bits(input int w);
        return w + 8;
    endfunction

    // squares, sum, one stage per root bit, one stage per quotient bit
    function automatic int norm_lat(input int w);
        return 2 + sqrt_bits(w) + QUOT_BITS;
    endfunction

endpackage

@@ sv/pfs_norm.sv @@
// ----------------------------------------------------------------------------
// pfs_norm
// Pipelined vector normalize: exact floor square root one bit per stage,
// then a restoring divide one quotient bit per stage, giving signed 1.14.
// ----------------------------------------------------------------------------
module pfs_norm #(
    parameter int W = pfs_pkg::DIR_W
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [W-1:0]               i_vx,
    input  logic signed [W-1:0]               i_vy,
    input  logic signed [W-1:0]               i_vz,
    output logic signed [pfs_pkg::UNIT_W-1:0] o_ux,
    output logic signed [pfs_pkg::UNIT_W-1:0] o_uy,
    output logic signed [pfs_pkg::UNIT_W-1:0] o_uz
);

    localparam int SW = 2 * W;
    localparam int XW = 2 * W + 16;
    localparam int K  = pfs_pkg::sqrt_bits(W);
    localparam int QB = pfs_pkg::QUOT_BITS;
    localparam int NW = W + 22;
    localparam int UW = pfs_pkg::UNIT_W;

    logic signed [W-1:0] v [3];
    logic [W-1:0]        mag [3];

    logic [W-1:0]  r_amag [3];
    logic          r_aneg [3];
    logic [SW-1:0] r_asq  [3];

    logic [XW-1:0] r_x;
    logic [W-1:0]  r_bmag [3];
    logic          r_bneg [3];

    logic [XW-1:0] r_rem  [K];
    logic [K-1:0]  r_root [K];
    logic [W-1:0]  r_smag [K][3];
    logic          r_sneg [K][3];

    logic [NW-1:0] r_drem [QB][3];
    logic [QB-1:0] r_quo  [QB][3];
    logic [K-1:0]  r_dlen [QB];
    logic          r_dneg [QB][3];

    logic signed [UW-1:0] u [3];

    assign v[0] = i_vx;
    assign v[1] = i_vy;
    assign v[2] = i_vz;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mag[c] = v[c][W-1] ? W'(-v[c]) : W'(v[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_amag[c] <= mag[c];
                r_aneg[c] <= v[c][W-1];
                r_asq[c]  <= SW'(mag[c]) * SW'(mag[c]);
            end
            // length squared scaled by 2^16
            r_x    <= {SW'(r_asq[0] + r_asq[1] + r_asq[2]), 16'b0};
            r_bmag <= r_amag;
            r_bneg <= r_aneg;
        end
    end

    for (genvar gi = 0; gi < K; gi++) begin : g_sqrt
        localparam int B = K - 1 - gi;
        logic [XW-1:0] a_rem;
        logic [K-1:0]  a_root;
        logic [W-1:0]  a_mag [3];
        logic          a_neg [3];
        logic [XW:0]   trial;
        logic          take;

        if (gi == 0) begin : g_first
            always_comb begin
                a_rem  = r_x;
                a_root = '0;
                a_mag  = r_bmag;
                a_neg  = r_bneg;
            end
        end else begin : g_next
            always_comb begin
                a_rem  = r_rem[gi-1];
                a_root = r_root[gi-1];
                a_mag  = r_smag[gi-1];
                a_neg  = r_sneg[gi-1];
            end
        end

        // (root + 2^B)^2 - root^2
        always_comb begin
            trial = ((XW+1)'(a_root) << (B + 1)) + ((XW+1)'(1) << (2 * B));
            take  = {1'b0, a_rem} >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi]  <= take ? XW'({1'b0, a_rem} - trial) : a_rem;
                r_root[gi] <= take ? (a_root | (K'(1) << B)) : a_root;
                r_smag[gi] <= a_mag;
                r_sneg[gi] <= a_neg;
            end
        end
    end

    for (genvar gj = 0; gj < QB; gj++) begin : g_div
        localparam int B = QB - 1 - gj;
        logic [NW-1:0] a_rem [3];
        logic [QB-1:0] a_quo [3];
        logic [K-1:0]  a_len;
        logic          a_neg [3];
        logic [NW-1:0] den;
        logic [2:0]    take;

        if (gj == 0) begin : g_first
            always_comb begin
                a_len = r_root[K-1];
                a_neg = r_sneg[K-1];
                for (int c = 0; c < 3; c++) begin
                    a_rem[c] = NW'(r_smag[K-1][c]) << 22;
                    a_quo[c] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                a_len = r_dlen[gj-1];
                a_neg = r_dneg[gj-1];
                a_rem = r_drem[gj-1];
                a_quo = r_quo[gj-1];
            end
        end

        always_comb begin
            den = NW'(a_len) << B;
            for (int c = 0; c < 3; c++) begin
                take[c] = a_rem[c] >= den;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    r_drem[gj][c] <= take[c] ? (a_rem[c] - den) : a_rem[c];
                    r_quo[gj][c]  <= take[c] ? (a_quo[c] | (QB'(1) << B)) : a_quo[c];
                end
                r_dlen[gj] <= a_len;
                r_dneg[gj] <= a_neg;
            end
        end
    end

    // zero-length vector gives the zero vector
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_dlen[QB-1] == '0) begin
                u[c] = '0;
            end else if (r_dneg[QB-1][c]) begin
                u[c] = UW'(0) - UW'(r_quo[QB-1][c]);
            end else begin
                u[c] = UW'(r_quo[QB-1][c]);
            end
        end
    end

    assign o_ux = u[0];
    assign o_uy = u[1];
    assign o_uz = u[2];

endmodule

@@ sv/phong_fragment_shader.sv @@
// ----------------------------------------------------------------------------
// phong_fragment_shader
// Phong shading of one fragment per clock, unless the output is held, against a point light and a camera.
// ----------------------------------------------------------------------------
// The shader takes one fragment request per clock while no finished color is
// held at the output; results leave in request order. Most of the pipeline
// depth lies in the two normalize pipelines in series (light direction, then
// reflected ray), each a square root resolved one bit per stage followed by a
// divide resolved one quotient bit per stage. The whole pipeline advances on
// one enable, which drops only while a finished color is held at the output,
// so o_ready follows the output side and the throughput is one fragment per
// clock while the output is not held. Light, eye and light color registers
// are to be written while no fragment is in flight.
module phong_fragment_shader (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pfs_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [pfs_pkg::COL_W-1:0]           i_base_r,
    input  logic [pfs_pkg::COL_W-1:0]           i_base_g,
    input  logic [pfs_pkg::COL_W-1:0]           i_base_b,
    input  logic signed [pfs_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [pfs_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [pfs_pkg::POS_W-1:0]    i_pos_z,
    input  logic signed [pfs_pkg::NRM_W-1:0]    i_norm_x,
    input  logic signed [pfs_pkg::NRM_W-1:0]    i_norm_y,
    input  logic signed [pfs_pkg::NRM_W-1:0]    i_norm_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pfs_pkg::COL_W-1:0]           o_out_r,
    output logic [pfs_pkg::COL_W-1:0]           o_out_g,
    output logic [pfs_pkg::COL_W-1:0]           o_out_b
);

    localparam int DW  = pfs_pkg::DIR_W;
    localparam int RW  = pfs_pkg::REFL_W;
    localparam int PW  = pfs_pkg::POS_W;
    localparam int NW  = pfs_pkg::NRM_W;
    localparam int CW  = pfs_pkg::COL_W;
    localparam int UW  = pfs_pkg::UNIT_W;
    localparam int TW  = pfs_pkg::DOT_W;
    localparam int FW  = pfs_pkg::DIFF_W;
    localparam int SPW = pfs_pkg::SPEC_W;
    localparam int NL  = pfs_pkg::norm_lat(DW);
    localparam int NR  = pfs_pkg::norm_lat(RW);
    localparam int LAT = 1 + NL + 4 + NR + 11;

    // configuration
    logic signed [PW-1:0] r_light_x, r_light_y, r_light_z;
    logic signed [PW-1:0] r_eye_x, r_eye_y, r_eye_z;
    logic [pfs_pkg::CFG_W-1:0] r_light_rgb;
    logic [CW-1:0] lc [3];

    logic           en;
    logic [LAT-1:0] r_vld;

    // stage 0
    pfs_pkg::t_rgb         r0_base;
    logic signed [NW-1:0]  r0_n  [3];
    logic signed [DW-1:0]  r0_vl [3];
    logic signed [DW-1:0]  r0_ve [3];

    // delay alongside light/eye normalize
    pfs_pkg::t_rgb         r_d1_base [NL];
    logic signed [NW-1:0]  r_d1_n    [NL][3];

    pfs_pkg::t_unit l_u [3];
    pfs_pkg::t_unit e_u [3];
    pfs_pkg::t_unit r_u [3];

    logic signed [TW-1:0]  r1_ln [3];
    pfs_pkg::t_unit        r1_l [3], r1_e [3];
    logic signed [NW-1:0]  r1_n [3];
    pfs_pkg::t_rgb         r1_base;

    logic signed [TW-1:0]  r2_nl;
    logic [FW-1:0]         r2_diff;
    pfs_pkg::t_unit        r2_l [3], r2_e [3];
    logic signed [NW-1:0]  r2_n [3];
    pfs_pkg::t_rgb         r2_base;

    logic signed [TW+NW-1:0] r3_p [3];
    pfs_pkg::t_unit        r3_l [3], r3_e [3];
    logic [FW-1:0]         r3_diff;
    pfs_pkg::t_rgb         r3_base;

    logic signed [RW-1:0]  r4_rv [3];
    pfs_pkg::t_unit        r4_e [3];
    logic [FW-1:0]         r4_diff;
    pfs_pkg::t_rgb         r4_base;

    // delay alongside reflection normalize
    pfs_pkg::t_rgb         r_d2_base [NR];
    logic [FW-1:0]         r_d2_diff [NR];
    pfs_pkg::t_unit        r_d2_e    [NR][3];

    logic signed [TW-1:0]  r5_er [3];
    logic [FW-1:0]         r5_diff;
    pfs_pkg::t_rgb         r5_base;

    logic signed [TW-1:0]  s_sum;
    logic [SPW-1:0]        spec0;

    // clamped specular base, then five squarings
    logic [SPW-1:0]        r_q     [6];
    logic [FW-1:0]         r_qdiff [6];
    pfs_pkg::t_rgb         r_qbase [6];

    logic [24:0]           r_sa [3];
    logic [27:0]           r_sb;
    logic [32:0]           r_ta [3];
    logic [35:0]           r_tb [3];
    logic [20:0]           r_m  [3];
    logic [48:0]           nsum [3];
    logic [16:0]           qt   [3];
    logic [CW-1:0]         n_out [3];
    logic [CW-1:0]         r_out [3];

    assign en      = ~r_vld[LAT-1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];
    assign o_out_r = r_out[0];
    assign o_out_g = r_out[1];
    assign o_out_b = r_out[2];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lc[c] = r_light_rgb[CW*c +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x   <= pfs_pkg::RST_LIGHT_X;
            r_light_y   <= pfs_pkg::RST_LIGHT_Y;
            r_light_z   <= pfs_pkg::RST_LIGHT_Z;
            r_eye_x     <= pfs_pkg::RST_EYE_X;
            r_eye_y     <= pfs_pkg::RST_EYE_Y;
            r_eye_z     <= pfs_pkg::RST_EYE_Z;
            r_light_rgb <= pfs_pkg::RST_LIGHT_RGB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfs_pkg::REG_LIGHT_X:   r_light_x   <= i_cfg_data[PW-1:0];
                pfs_pkg::REG_LIGHT_Y:   r_light_y   <= i_cfg_data[PW-1:0];
                pfs_pkg::REG_LIGHT_Z:   r_light_z   <= i_cfg_data[PW-1:0];
                pfs_pkg::REG_EYE_X:     r_eye_x     <= i_cfg_data[PW-1:0];
                pfs_pkg::REG_EYE_Y:     r_eye_y     <= i_cfg_data[PW-1:0];
                pfs_pkg::REG_EYE_Z:     r_eye_z     <= i_cfg_data[PW-1:0];
                pfs_pkg::REG_LIGHT_RGB: r_light_rgb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    pfs_norm #(.W(DW)) u_norm_l (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vx  (r0_vl[0]),
        .i_vy  (r0_vl[1]),
        .i_vz  (r0_vl[2]),
        .o_ux  (l_u[0]),
        .o_uy  (l_u[1]),
        .o_uz  (l_u[2])
    );

    pfs_norm #(.W(DW)) u_norm_e (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vx  (r0_ve[0]),
        .i_vy  (r0_ve[1]),
        .i_vz  (r0_ve[2]),
        .o_ux  (e_u[0]),
        .o_uy  (e_u[1]),
        .o_uz  (e_u[2])
    );

    pfs_norm #(.W(RW)) u_norm_r (
        .i_clk (i_clk),
        .i_en  (en),
        .i_vx  (r4_rv[0]),
        .i_vy  (r4_rv[1]),
        .i_vz  (r4_rv[2]),
        .o_ux  (r_u[0]),
        .o_uy  (r_u[1]),
        .o_uz  (r_u[2])
    );

    always_comb begin
        s_sum = r5_er[0] + r5_er[1] + r5_er[2];
        if (s_sum <= 0) begin
            spec0 = '0;
        end else if ((s_sum >>> 14) > TW'(pfs_pkg::SPEC_MAX)) begin
            spec0 = pfs_pkg::SPEC_MAX;
        end else begin
            spec0 = SPW'(s_sum >>> 14);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            nsum[c] = 49'({r_ta[c], 14'b0}) + 49'(r_tb[c]) * 49'(255)
                    + pfs_pkg::SHADE_RND;
            // divide by 255 for values below 2^16
            qt[c] = 17'(r_m[c]) + 17'd1 + 17'(r_m[c] >> 8);
            if (r_m[c] >= pfs_pkg::SAT_LIM) begin
                n_out[c] = '1;
            end else begin
                n_out[c] = qt[c][15:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 0: directions to light and eye
            r0_base <= '{b: i_base_b, g: i_base_g, r: i_base_r};
            r0_n[0] <= i_norm_x;
            r0_n[1] <= i_norm_y;
            r0_n[2] <= i_norm_z;
            r0_vl[0] <= DW'(r_light_x) - DW'(i_pos_x);
            r0_vl[1] <= DW'(r_light_y) - DW'(i_pos_y);
            r0_vl[2] <= DW'(r_light_z) - DW'(i_pos_z);
            r0_ve[0] <= DW'(r_eye_x) - DW'(i_pos_x);
            r0_ve[1] <= DW'(r_eye_y) - DW'(i_pos_y);
            r0_ve[2] <= DW'(r_eye_z) - DW'(i_pos_z);

            r_d1_base[0] <= r0_base;
            r_d1_n[0]    <= r0_n;
            for (int k = 1; k < NL; k++) begin
                r_d1_base[k] <= r_d1_base[k-1];
                r_d1_n[k]    <= r_d1_n[k-1];
            end

            // l.n
            for (int c = 0; c < 3; c++) begin
                r1_ln[c] <= l_u[c] * r_d1_n[NL-1][c];
            end
            r1_l    <= l_u;
            r1_e    <= e_u;
            r1_n    <= r_d1_n[NL-1];
            r1_base <= r_d1_base[NL-1];

            r2_nl   <= r1_ln[0] + r1_ln[1] + r1_ln[2];
            r2_diff <= ((r1_ln[0] + r1_ln[1] + r1_ln[2]) > 0)
                     ? FW'((r1_ln[0] + r1_ln[1] + r1_ln[2]) >>> 14) : '0;
            r2_l    <= r1_l;
            r2_e    <= r1_e;
            r2_n    <= r1_n;
            r2_base <= r1_base;

            for (int c = 0; c < 3; c++) begin
                r3_p[c] <= r2_nl * r2_n[c];
            end
            r3_l    <= r2_l;
            r3_e    <= r2_e;
            r3_diff <= r2_diff;
            r3_base <= r2_base;

            // reflected ray: floor(2 nl n / 2^28) - l
            for (int c = 0; c < 3; c++) begin
                r4_rv[c] <= RW'(r3_p[c] >>> 27) - RW'(r3_l[c]);
            end
            r4_e    <= r3_e;
            r4_diff <= r3_diff;
            r4_base <= r3_base;

            r_d2_base[0] <= r4_base;
            r_d2_diff[0] <= r4_diff;
            r_d2_e[0]    <= r4_e;
            for (int k = 1; k < NR; k++) begin
                r_d2_base[k] <= r_d2_base[k-1];
                r_d2_diff[k] <= r_d2_diff[k-1];
                r_d2_e[k]    <= r_d2_e[k-1];
            end

            // e.r
            for (int c = 0; c < 3; c++) begin
                r5_er[c] <= r_d2_e[NR-1][c] * r_u[c];
            end
            r5_diff <= r_d2_diff[NR-1];
            r5_base <= r_d2_base[NR-1];

            r_q[0]     <= spec0;
            r_qdiff[0] <= r5_diff;
            r_qbase[0] <= r5_base;
            for (int k = 1; k < 6; k++) begin
                r_q[k]     <= SPW'((30'(r_q[k-1]) * 30'(r_q[k-1])) >> 14);
                r_qdiff[k] <= r_qdiff[k-1];
                r_qbase[k] <= r_qbase[k-1];
            end

            r_sa[0] <= 25'(r_qdiff[5] + pfs_pkg::AMBIENT_Q14) * 25'(r_qbase[5].r);
            r_sa[1] <= 25'(r_qdiff[5] + pfs_pkg::AMBIENT_Q14) * 25'(r_qbase[5].g);
            r_sa[2] <= 25'(r_qdiff[5] + pfs_pkg::AMBIENT_Q14) * 25'(r_qbase[5].b);
            r_sb    <= 28'(r_q[5]) * 28'(pfs_pkg::SPEC_WT_Q14);

            for (int c = 0; c < 3; c++) begin
                r_ta[c]  <= 33'(r_sa[c]) * 33'(lc[c]);
                r_tb[c]  <= 36'(r_sb) * 36'(lc[c]);
                r_m[c]   <= 21'(nsum[c] >> 28);
                r_out[c] <= n_out[c];
            end
        end
    end

endmodule

@@ sv/pfs_check.sv @@
// ----------------------------------------------------------------------------
// pfs_check
// Port-level checks of the shader pipeline stall and reset behavior.
// ----------------------------------------------------------------------------
module pfs_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [pfs_pkg::COL_W-1:0]    o_out_r,
    input logic [pfs_pkg::COL_W-1:0]    o_out_g,
    input logic [pfs_pkg::COL_W-1:0]    o_out_b
);

    // a held result keeps its color
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_r) && $stable(o_out_g)
            && $stable(o_out_b))
        else $error("output changed while held");

    // a held result freezes the pipeline, so no request is taken
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request taken while output stalled");

    // nothing at the output means the pipeline moves
    a_free_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result present right after reset");

endmodule

bind phong_fragment_shader pfs_check u_pfs_check (.*);

@@ bench/tb_phong_fragment_shader.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phong_fragment_shader
// Self-checking bench: random and directed fragments under several light, eye
// and color settings, each shaded color compared against a fixed-point model.
// ----------------------------------------------------------------------------
module tb_phong_fragment_shader;

    localparam int COL_W     = pfs_pkg::COL_W;
    localparam int POS_W     = pfs_pkg::POS_W;
    localparam int NRM_W     = pfs_pkg::NRM_W;
    localparam int CFG_W     = pfs_pkg::CFG_W;
    localparam int CFG_IDX_W = pfs_pkg::CFG_IDX_W;

    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        logic [COL_W-1:0]        r, g, b;
        logic signed [POS_W-1:0] px, py, pz;
        logic signed [NRM_W-1:0] nx, ny, nz;
    } t_frag;

    class shade_scoreboard;
        logic signed [POS_W-1:0] lx, ly, lz, ex, ey, ez;
        logic [CFG_W-1:0]        lrgb;
        pfs_pkg::t_rgb           color_q[$];
        int                      errors;

        function new();
            lx = pfs_pkg::RST_LIGHT_X; ly = pfs_pkg::RST_LIGHT_Y; lz = pfs_pkg::RST_LIGHT_Z;
            ex = pfs_pkg::RST_EYE_X;   ey = pfs_pkg::RST_EYE_Y;   ez = pfs_pkg::RST_EYE_Z;
            lrgb = pfs_pkg::RST_LIGHT_RGB;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                pfs_pkg::REG_LIGHT_X:   lx = d[15:0];
                pfs_pkg::REG_LIGHT_Y:   ly = d[15:0];
                pfs_pkg::REG_LIGHT_Z:   lz = d[15:0];
                pfs_pkg::REG_EYE_X:     ex = d[15:0];
                pfs_pkg::REG_EYE_Y:     ey = d[15:0];
                pfs_pkg::REG_EYE_Z:     ez = d[15:0];
                pfs_pkg::REG_LIGHT_RGB: lrgb = d;
                default: ;
            endcase
        endfunction

        function longint unsigned isqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // length zero gives the zero vector
        function void normalize(input longint v[3], output longint u[3]);
            longint unsigned len2, len, mag;
            len2 = 0;
            for (int i = 0; i < 3; i++) len2 += longint'(v[i] * v[i]);
            len = isqrt(len2 * 65536);
            for (int i = 0; i < 3; i++) begin
                if (len == 0) begin
                    u[i] = 0;
                end else begin
                    mag = (v[i] < 0) ? -v[i] : v[i];
                    mag = (mag * 4194304) / len;
                    u[i] = (v[i] < 0) ? -longint'(mag) : longint'(mag);
                end
            end
        endfunction

        function logic [COL_W-1:0] shade_chan(longint unsigned base, longint unsigned lc,
                                              longint diff, longint spec);
            longint unsigned n, o, den;
            den = 64'd255 << 28;
            n = longint'(diff + 4915) * base * lc * 16384 + longint'(spec) * 9830 * lc * 255;
            o = (n + den / 2) / den;
            return (o > 255) ? 8'd255 : o[7:0];
        endfunction

        function void note_request(t_frag f);
            longint p[3], n[3], v[3], l[3], e[3], rf[3];
            longint nl, diff, s, spec;
            pfs_pkg::t_rgb c;
            p[0] = f.px; p[1] = f.py; p[2] = f.pz;
            n[0] = f.nx; n[1] = f.ny; n[2] = f.nz;
            v[0] = longint'(lx) - p[0]; v[1] = longint'(ly) - p[1]; v[2] = longint'(lz) - p[2];
            normalize(v, l);
            nl = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
            diff = (nl > 0) ? (nl >>> 14) : 0;
            for (int i = 0; i < 3; i++) v[i] = (-l[i] * 268435456 + 2 * nl * n[i]) >>> 28;
            normalize(v, rf);
            v[0] = longint'(ex) - p[0]; v[1] = longint'(ey) - p[1]; v[2] = longint'(ez) - p[2];
            normalize(v, e);
            s = e[0] * rf[0] + e[1] * rf[1] + e[2] * rf[2];
            spec = (s > 0) ? (s >>> 14) : 0;
            if (spec > 16384) spec = 16384;
            for (int i = 0; i < 5; i++) spec = (spec * spec) >>> 14;
            c.r = shade_chan(f.r, lrgb[7:0], diff, spec);
            c.g = shade_chan(f.g, lrgb[15:8], diff, spec);
            c.b = shade_chan(f.b, lrgb[23:16], diff, spec);
            color_q.push_back(c);
        endfunction

        function void check_result(pfs_pkg::t_rgb got);
            pfs_pkg::t_rgb want;
            if (color_q.size() == 0) begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                         got.r, got.g, got.b);
                errors++;
                return;
            end
            want = color_q.pop_front();
            if (got.r !== want.r) begin
                $display("%0t: out_r expected %0d actual %0d", $time, want.r, got.r);
                errors++;
            end
            if (got.g !== want.g) begin
                $display("%0t: out_g expected %0d actual %0d", $time, want.g, got.g);
                errors++;
            end
            if (got.b !== want.b) begin
                $display("%0t: out_b expected %0d actual %0d", $time, want.b, got.b);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk, i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_valid, o_ready, o_valid, i_ready;
    logic [COL_W-1:0]        i_base_r, i_base_g, i_base_b;
    logic signed [POS_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [NRM_W-1:0] i_norm_x, i_norm_y, i_norm_z;
    logic [COL_W-1:0]        o_out_r, o_out_g, o_out_b;

    shade_scoreboard sb = new();
    int              idle_cycles;
    int              burst_left;
    logic [15:0]     ready_pattern;
    int              pattern_age;

    phong_fragment_shader u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver stall pattern, reloaded now and then; all-ones gives full-rate stretches
    always @(posedge i_clk) begin
        if (pattern_age == 63) begin
            pattern_age <= 0;
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'($urandom) | 16'h0001;
                default: ready_pattern <= 16'($urandom) | 16'($urandom);
            endcase
        end else begin
            pattern_age <= pattern_age + 1;
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
        end
        i_ready <= ready_pattern[0];
        if (o_valid && i_ready)
            sb.check_result('{b: o_out_b, g: o_out_g, r: o_out_r});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("phong_fragment_shader: mismatch");
            $finish;
        end
    end

    task automatic send_frag(input t_frag f);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_base_r <= f.r;  i_base_g <= f.g;  i_base_b <= f.b;
        i_pos_x  <= f.px; i_pos_y  <= f.py; i_pos_z  <= f.pz;
        i_norm_x <= f.nx; i_norm_y <= f.ny; i_norm_z <= f.nz;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(f);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.color_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    task automatic cfg_all(input logic [15:0] lx, ly, lz, ex, ey, ez,
                           input logic [CFG_W-1:0] rgb);
        cfg_write(pfs_pkg::REG_LIGHT_X, CFG_W'(lx));
        cfg_write(pfs_pkg::REG_LIGHT_Y, CFG_W'(ly));
        cfg_write(pfs_pkg::REG_LIGHT_Z, CFG_W'(lz));
        cfg_write(pfs_pkg::REG_EYE_X, CFG_W'(ex));
        cfg_write(pfs_pkg::REG_EYE_Y, CFG_W'(ey));
        cfg_write(pfs_pkg::REG_EYE_Z, CFG_W'(ez));
        cfg_write(pfs_pkg::REG_LIGHT_RGB, rgb);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_pos();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_norm();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic t_frag rand_frag();
        t_frag f;
        f.r = 8'($urandom); f.g = 8'($urandom); f.b = 8'($urandom);
        f.px = rand_pos(); f.py = rand_pos(); f.pz = rand_pos();
        f.nx = rand_norm(); f.ny = rand_norm(); f.nz = rand_norm();
        // sometimes put the fragment on the light or on the eye
        case ($urandom_range(0, 24))
            0: begin f.px = sb.lx; f.py = sb.ly; f.pz = sb.lz; end
            1: begin f.px = sb.ex; f.py = sb.ey; f.pz = sb.ez; end
            default: ;
        endcase
        return f;
    endfunction

    function automatic t_frag mk(logic [7:0] r, g, b, logic signed [15:0] px, py, pz,
                                 logic signed [15:0] nx, ny, nz);
        t_frag f;
        f.r = r; f.g = g; f.b = b;
        f.px = px; f.py = py; f.pz = pz;
        f.nx = nx; f.ny = ny; f.nz = nz;
        return f;
    endfunction

    initial begin
        i_clk = 1'b0; i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_ready = 1'b0;
        i_base_r = '0; i_base_g = '0; i_base_b = '0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_norm_x = '0; i_norm_y = '0; i_norm_z = '0;
        ready_pattern = 16'hFFFF; pattern_age = 0;
        idle_cycles = 0; burst_left = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: head-on light, light and eye on the fragment, odd normals
        send_frag(mk(0, 0, 0, 0, 0, 0, 0, 0, 16384));
        send_frag(mk(255, 255, 255, 0, 0, 0, 0, 0, 16384));
        send_frag(mk(255, 128, 1, 0, 0, 0, 11585, 11585, 0));
        send_frag(mk(200, 100, 50, 8192, 8192, 0, 0, 0, 16384));
        send_frag(mk(90, 180, 255, 0, 0, 6963, 0, 0, 16384));
        send_frag(mk(255, 255, 255, 0, 0, 0, 0, 0, 0));
        send_frag(mk(255, 255, 255, 0, 0, 0, 32767, 32767, 32767));
        send_frag(mk(255, 255, 255, 0, 0, 0, -32768, -32768, -32768));
        send_frag(mk(255, 0, 255, -32768, -32768, -32768, -16384, -16384, -16384));
        send_frag(mk(0, 255, 0, 32767, 32767, 32767, 16384, 16384, 16384));
        send_frag(mk(77, 88, 99, 0, 0, 0, -16384, 0, 0));
        send_frag(mk(255, 255, 255, 4096, 4096, 0, 0, 0, -16384));
        drain();

        // extreme settings
        cfg_all(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h000000);
        send_frag(mk(255, 255, 255, 0, 0, 0, -11585, -11585, 0));
        send_frag(mk(255, 255, 255, -32768, -32768, -32768, 0, 16384, 0));
        send_frag(mk(255, 255, 255, 32767, 32767, 32767, 0, 0, 16384));
        drain();
        cfg_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 24'hFFFFFF);
        send_frag(mk(255, 255, 255, 0, 0, 0, 9459, 9459, 9459));
        send_frag(mk(255, 255, 255, 32767, 32767, 32767, 9459, 9459, 9459));
        send_frag(mk(1, 2, 3, 0, 0, 0, -9459, -9459, -9459));
        send_frag(mk(255, 255, 255, -32768, -32768, -32768, 16384, 16384, 16384));
        drain();

        // index beyond the register list is ignored
        cfg_write(3'd7, 24'h5A5A5A);
        i_cfg_we <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 1) begin
                cfg_all(pfs_pkg::RST_LIGHT_X, pfs_pkg::RST_LIGHT_Y, pfs_pkg::RST_LIGHT_Z,
                        pfs_pkg::RST_EYE_X, pfs_pkg::RST_EYE_Y, pfs_pkg::RST_EYE_Z,
                        pfs_pkg::RST_LIGHT_RGB);
            end else if (ph > 1) begin
                cfg_all(rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                        rand_pos(), CFG_W'($urandom));
            end
            repeat (125) send_frag(rand_frag());
            drain();
        end

        if (sb.errors == 0 && sb.color_q.size() == 0)
            $display("phong_fragment_shader: match");
        else
            $display("phong_fragment_shader: mismatch");
        $finish;
    end

endmodule
